FILE: design/tce_pkg.sv
// shared types and constants of the triggered capture engine
package tce_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_ARM   = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  localparam logic [2:0] MODE_NONE  = 3'd0;
  localparam logic [2:0] MODE_RISE  = 3'd1;
  localparam logic [2:0] MODE_FALL  = 3'd2;
  localparam logic [2:0] MODE_ABOVE = 3'd3;
  localparam logic [2:0] MODE_BELOW = 3'd4;

  localparam logic [CFG_INDEX_W-1:0] REG_MODE    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LEVEL   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PRE     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_POST    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_ENABLE  = 3'd6;

  localparam logic [1:0] STATE_IDLE     = 2'd0;
  localparam logic [1:0] STATE_ARMED    = 2'd1;
  localparam logic [1:0] STATE_CAPTURED = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'b001,
    PH_ARMED    = 3'b010,
    PH_CAPTURED = 3'b100
  } phase_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [15:0] level;
    logic [1:0]         channel;
    logic [9:0]         pre_count;
    logic [9:0]         post_count;
    logic [2:0]         active;
    logic [3:0]         enable;
  } cfg_t;

  typedef struct packed {
    cmd_t       op;
    logic       trig_en;
    logic [9:0] read_pos;
    logic [1:0] read_lane;
  } item_ctrl_t;

endpackage

FILE: design/tce_front.sv
// front end: accepts items, masks lanes and picks the trigger sample
module tce_front #(
  parameter int LANES       = 4,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tce_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    cmd,
  input  logic signed [15:0]            sample_a,
  input  logic signed [15:0]            sample_b,
  input  logic signed [15:0]            sample_c,
  input  logic signed [15:0]            sample_d,
  input  logic [9:0]                    read_position,
  input  logic [1:0]                    read_lane,
  output logic                          push_valid,
  input  logic                          push_ready,
  output tce_pkg::item_ctrl_t           ctrl,
  output logic [LANES*SAMPLE_BITS-1:0]  word,
  output logic [SAMPLE_BITS-1:0]        tval
);

  logic signed [SAMPLE_BITS-1:0] raw_lane [4];
  logic [3:0]                    lane_on;
  logic [LANES*SAMPLE_BITS-1:0]  word_c;
  logic [SAMPLE_BITS-1:0]        tval_c;
  tce_pkg::item_ctrl_t           ctrl_c;
  logic                          valid;

  assign raw_lane[0] = SAMPLE_BITS'(sample_a);
  assign raw_lane[1] = SAMPLE_BITS'(sample_b);
  assign raw_lane[2] = SAMPLE_BITS'(sample_c);
  assign raw_lane[3] = SAMPLE_BITS'(sample_d);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      lane_on[i] = (i < LANES) && (cfg.active > 3'(i)) && cfg.enable[i];
    end
    for (int i = 0; i < LANES; i++) begin
      word_c[i*SAMPLE_BITS +: SAMPLE_BITS] = lane_on[i] ? raw_lane[i] : '0;
    end
    // arm loads the raw trigger lane, a tick sees the stored (masked) value
    if (tce_pkg::cmd_t'(cmd) == tce_pkg::CMD_ARM || lane_on[cfg.channel]) begin
      tval_c = raw_lane[cfg.channel];
    end else begin
      tval_c = '0;
    end
    ctrl_c.op        = tce_pkg::cmd_t'(cmd);
    ctrl_c.trig_en   = (cfg.mode != tce_pkg::MODE_NONE) &&
                       ({1'b0, cfg.channel} < cfg.active) &&
                       ({1'b0, cfg.channel} < 3'(LANES));
    ctrl_c.read_pos  = read_position;
    ctrl_c.read_lane = read_lane;
  end

  assign in_ready   = !valid || push_ready;
  assign push_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid <= 1'b1;
    end else if (push_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ctrl <= ctrl_c;
      word <= word_c;
      tval <= tval_c;
    end
  end

endmodule

FILE: design/tce_fifo.sv
// two-entry item queue between front end and back end
module tce_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  logic [W-1:0] entry [2];
  logic         wptr;
  logic         rptr;
  logic [1:0]   count;
  logic         push_fire;
  logic         pop_fire;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = entry[rptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push_fire) begin
        wptr <= !wptr;
      end
      if (pop_fire) begin
        rptr <= !rptr;
      end
      if (push_fire && !pop_fire) begin
        count <= count + 2'd1;
      end else if (pop_fire && !push_fire) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      entry[wptr] <= push_data;
    end
  end

endmodule

FILE: design/tce_back.sv
// back end: capture state, trigger test, sample store and result register
module tce_back #(
  parameter int DEPTH       = 1024,
  parameter int LANES       = 4,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tce_pkg::cfg_t                 cfg,
  input  logic                          pop_valid,
  output logic                          pop_ready,
  input  tce_pkg::item_ctrl_t           ctrl,
  input  logic [LANES*SAMPLE_BITS-1:0]  word,
  input  logic [SAMPLE_BITS-1:0]        tval,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    capture_state,
  output logic [10:0]                   captured_count,
  output logic                          trigger_fired,
  output logic signed [15:0]            read_value,
  output logic                          read_ok
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = ((CW > 10) ? CW : 10) + 1;
  localparam int W  = LANES * SAMPLE_BITS;

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata;

  logic [AW-1:0]                 wp, wp_next, wp_inc, slot;
  logic [CW-1:0]                 seen, seen_next, seen_inc;
  logic [CW-1:0]                 total, total_next;
  logic [9:0]                    pp, pp_next;
  logic signed [SAMPLE_BITS-1:0] prev, prev_next;
  tce_pkg::phase_t               phase, phase_next;

  logic                          pop;
  logic                          we;
  logic                          re;
  logic                          hit;
  logic                          test;
  logic                          fired_c;
  logic                          ok_c;
  logic [1:0]                    code_c;
  logic [10:0]                   pp_inc;
  logic signed [31:0]            prev_w, now_w, lvl_w;
  logic [SW-1:0]                 dep_s, pre_c, sum_c, post_total, k, slot_raw, slot_fix;
  logic                          pos_lt, k_le_seen, lane_ok;

  logic [1:0]                    r_lane;
  logic signed [SAMPLE_BITS-1:0] sel;

  assign pop       = pop_valid && (!out_valid || out_ready);
  assign pop_ready = !out_valid || out_ready;

  // counters and trigger test
  always_comb begin
    wp_inc   = (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
    seen_inc = (seen < CW'(DEPTH)) ? seen + 1'b1 : seen;
    prev_w   = 32'(prev);
    now_w    = 32'(signed'(tval));
    lvl_w    = 32'(cfg.level);
    case (cfg.mode)
      tce_pkg::MODE_RISE:  test = (prev_w < lvl_w) && (now_w >= lvl_w);
      tce_pkg::MODE_FALL:  test = (prev_w > lvl_w) && (now_w <= lvl_w);
      tce_pkg::MODE_ABOVE: test = (now_w >= lvl_w);
      tce_pkg::MODE_BELOW: test = (now_w <= lvl_w);
      default:             test = 1'b0;
    endcase
    hit        = ctrl.trig_en && test;
    dep_s      = SW'(DEPTH);
    pre_c      = (SW'(cfg.pre_count) > dep_s) ? dep_s : SW'(cfg.pre_count);
    sum_c      = pre_c + SW'(cfg.post_count);
    post_total = (sum_c > dep_s) ? dep_s : sum_c;
    pp_inc     = 11'(pp) + 11'd1;
  end

  // read window: distance back from the write pointer
  always_comb begin
    k         = SW'(total) - SW'(ctrl.read_pos);
    pos_lt    = !k[SW-1] && (k != '0);
    k_le_seen = (SW'(seen) >= k);
    lane_ok   = ({1'b0, ctrl.read_lane} < cfg.active) &&
                ({1'b0, ctrl.read_lane} < 3'(LANES));
    slot_raw  = SW'(wp) - k;
    slot_fix  = slot_raw[SW-1] ? slot_raw + dep_s : slot_raw;
    slot      = slot_fix[AW-1:0];
  end

  always_comb begin
    wp_next    = wp;
    seen_next  = seen;
    total_next = total;
    pp_next    = pp;
    prev_next  = prev;
    phase_next = phase;
    we         = 1'b0;
    re         = 1'b0;
    fired_c    = 1'b0;
    ok_c       = 1'b0;
    if (pop) begin
      case (ctrl.op)
        tce_pkg::CMD_TICK: begin
          if (phase == tce_pkg::PH_ARMED) begin
            we        = 1'b1;
            wp_next   = wp_inc;
            seen_next = seen_inc;
            fired_c   = hit;
            if (ctrl.trig_en) begin
              prev_next = signed'(tval);
            end
            if (cfg.mode == tce_pkg::MODE_NONE) begin
              if (seen_inc >= CW'(DEPTH)) begin
                total_next = CW'(DEPTH);
                phase_next = tce_pkg::PH_CAPTURED;
              end
            end else if (pp == '0) begin
              if (hit && (SW'(seen_inc) >= pre_c)) begin
                pp_next = 10'd1;
              end
            end else begin
              pp_next = pp_inc[9:0];
              if (pp_inc >= {1'b0, cfg.post_count}) begin
                total_next = CW'(post_total);
                phase_next = tce_pkg::PH_CAPTURED;
              end
            end
          end
        end
        tce_pkg::CMD_ARM: begin
          wp_next    = '0;
          seen_next  = '0;
          pp_next    = '0;
          total_next = '0;
          prev_next  = signed'(tval);
          phase_next = tce_pkg::PH_ARMED;
        end
        tce_pkg::CMD_STOP: begin
          phase_next = tce_pkg::PH_IDLE;
        end
        default: begin
          ok_c = (phase == tce_pkg::PH_CAPTURED) && pos_lt && lane_ok && k_le_seen;
          re   = ok_c;
        end
      endcase
    end
  end

  always_comb begin
    unique case (phase_next)
      tce_pkg::PH_IDLE:     code_c = tce_pkg::STATE_IDLE;
      tce_pkg::PH_ARMED:    code_c = tce_pkg::STATE_ARMED;
      tce_pkg::PH_CAPTURED: code_c = tce_pkg::STATE_CAPTURED;
      default:              code_c = tce_pkg::STATE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp        <= '0;
      seen      <= '0;
      total     <= '0;
      pp        <= '0;
      prev      <= '0;
      phase     <= tce_pkg::PH_IDLE;
      out_valid <= 1'b0;
    end else begin
      wp    <= wp_next;
      seen  <= seen_next;
      total <= total_next;
      pp    <= pp_next;
      prev  <= prev_next;
      phase <= phase_next;
      if (pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register, held while the receiver stalls
  always_ff @(posedge clk) begin
    if (pop) begin
      capture_state  <= code_c;
      captured_count <= 11'(total_next);
      trigger_fired  <= fired_c;
      read_ok        <= ok_c;
      r_lane         <= ctrl.read_lane;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wp] <= word;
    end
    if (re) begin
      rdata <= mem[slot];
    end
  end

  always_comb begin
    sel = '0;
    for (int i = 0; i < LANES; i++) begin
      if (r_lane == 2'(i)) begin
        sel = rdata[i*SAMPLE_BITS +: SAMPLE_BITS];
      end
    end
    read_value = read_ok ? 16'(sel) : '0;
  end

endmodule

FILE: design/triggered_capture_engine_top.sv
// triggered capture engine: top level with configuration registers
//
// Records up to four channels into a circular sample store and replays them.
// Input channel (in_valid/in_ready) carries one command item: sample tick,
// arm, stop or read, with four samples and a read position and lane.
// Output channel (out_valid/out_ready) returns one result item per command:
// capture state, captured count, trigger flag and read value with read_ok.
// Configuration channel (cfg_valid/cfg_ready, always ready) writes the
// trigger mode, level, channel, pre and post counts, active channels and
// enable mask; write it only while no item is in flight.
// Throughput is one item per clock while the receiver does not stall. An
// accepted item passes through the front register and the queue, and
// the back end updates the capture counters and writes or reads the store
// in the cycle that moves the item into the result register.
// When the receiver stalls, the result register holds, the two-entry queue
// and then the front register fill, and in_ready drops. Reset clears the
// control state and restores the register defaults; the sample store is not
// cleared and needs no clearing pass, since a read only returns slots
// written since the last arm.
module triggered_capture_engine_top #(
  parameter int DEPTH       = 1024,
  parameter int LANES       = 4,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tce_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [tce_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          cmd,
  input  logic signed [15:0]                  sample_a,
  input  logic signed [15:0]                  sample_b,
  input  logic signed [15:0]                  sample_c,
  input  logic signed [15:0]                  sample_d,
  input  logic [9:0]                          read_position,
  input  logic [1:0]                          read_lane,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          capture_state,
  output logic [10:0]                         captured_count,
  output logic                                trigger_fired,
  output logic signed [15:0]                  read_value,
  output logic                                read_ok
);

  localparam int W  = LANES * SAMPLE_BITS;
  localparam int CB = $bits(tce_pkg::item_ctrl_t);
  localparam int QW = CB + W + SAMPLE_BITS;

  tce_pkg::cfg_t       cfg;
  tce_pkg::item_ctrl_t f_ctrl, b_ctrl;
  logic [W-1:0]        f_word, b_word;
  logic [SAMPLE_BITS-1:0] f_tval, b_tval;
  logic                push_valid, push_ready, pop_valid, pop_ready;
  logic [QW-1:0]       push_data, pop_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode       <= tce_pkg::MODE_NONE;
      cfg.level      <= '0;
      cfg.channel    <= '0;
      cfg.pre_count  <= '0;
      cfg.post_count <= 10'd1;
      cfg.active     <= 3'd1;
      cfg.enable     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tce_pkg::REG_MODE:    cfg.mode       <= cfg_data[2:0];
        tce_pkg::REG_LEVEL:   cfg.level      <= signed'(cfg_data[15:0]);
        tce_pkg::REG_CHANNEL: cfg.channel    <= cfg_data[1:0];
        tce_pkg::REG_PRE:     cfg.pre_count  <= cfg_data[9:0];
        tce_pkg::REG_POST:    cfg.post_count <= cfg_data[9:0];
        tce_pkg::REG_ACTIVE:  cfg.active     <= cfg_data[2:0];
        tce_pkg::REG_ENABLE:  cfg.enable     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  tce_front #(
    .LANES       (LANES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cmd           (cmd),
    .sample_a      (sample_a),
    .sample_b      (sample_b),
    .sample_c      (sample_c),
    .sample_d      (sample_d),
    .read_position (read_position),
    .read_lane     (read_lane),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .ctrl          (f_ctrl),
    .word          (f_word),
    .tval          (f_tval)
  );

  assign push_data = {f_ctrl, f_word, f_tval};

  tce_fifo #(
    .W (QW)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  assign b_ctrl = tce_pkg::item_ctrl_t'(pop_data[QW-1 -: CB]);
  assign b_word = pop_data[SAMPLE_BITS +: W];
  assign b_tval = pop_data[SAMPLE_BITS-1:0];

  tce_back #(
    .DEPTH       (DEPTH),
    .LANES       (LANES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .ctrl           (b_ctrl),
    .word           (b_word),
    .tval           (b_tval),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .capture_state  (capture_state),
    .captured_count (captured_count),
    .trigger_fired  (trigger_fired),
    .read_value     (read_value),
    .read_ok        (read_ok)
  );

endmodule

FILE: design/tce_checker.sv
// port-level checks of the capture engine results, bound to the top level
module tce_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         capture_state,
  input logic               trigger_fired,
  input logic signed [15:0] read_value,
  input logic               read_ok
);

  // state code is one of the three defined phases
  a_state_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (capture_state == tce_pkg::STATE_IDLE) ||
                  (capture_state == tce_pkg::STATE_ARMED) ||
                  (capture_state == tce_pkg::STATE_CAPTURED))
    else $error("capture_state carries an undefined code");

  // a good read only happens on a finished capture
  a_read_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && read_ok |-> capture_state == tce_pkg::STATE_CAPTURED)
    else $error("read_ok outside the captured phase");

  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !read_ok |-> read_value == 16'sd0)
    else $error("read_value nonzero without read_ok");

  // a trigger comes from a tick while armed, never from a read
  a_fire_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && trigger_fired |-> capture_state != tce_pkg::STATE_IDLE && !read_ok)
    else $error("trigger_fired on a non-tick item");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(capture_state) && $stable(read_value))
    else $error("result item changed while stalled");

endmodule

bind triggered_capture_engine_top tce_checker u_tce_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .capture_state (capture_state),
  .trigger_fired (trigger_fired),
  .read_value    (read_value),
  .read_ok       (read_ok)
);
